// ===== design/gamma_encode_rgb_to_byte_macros.svh =====
// ----------------------------------------------------------------------------
// gamma encoder assertion macros
// shared property forms for the gamma encoder checks
// ----------------------------------------------------------------------------
`ifndef GAMMA_ENCODE_RGB_TO_BYTE_MACROS_SVH
`define GAMMA_ENCODE_RGB_TO_BYTE_MACROS_SVH

// same-cycle implication
`define GAM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gamma encoder check failed");

// next-cycle implication
`define GAM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gamma encoder check failed");

`endif

// ===== design/gamma_enc_pkg.sv =====
// ----------------------------------------------------------------------------
// gamma encoder package
// shared types, constants and elaboration-time helpers
// ----------------------------------------------------------------------------
package gamma_enc_pkg;

   localparam int LIN_W         = 24;
   localparam int FRAC_BITS_DEF = 16;
   localparam int LOG_FRAC      = 28;
   localparam int LOG_N         = 28;
   localparam int DIV_N         = 34;
   localparam int EXP_N         = 28;
   localparam int ROOT_N        = 9;
   localparam int PIPE_LAT      = LOG_N + DIV_N + EXP_N + 5;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_LEGACY_MODE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAMMA_VALUE = 1'd1;

   localparam logic [15:0] GAMMA_DEFAULT = 16'd9011;
   localparam logic [17:0] LEG_SCALE     = 18'd260100;

   typedef struct packed {
      logic signed [LIN_W-1:0] red_linear;
      logic signed [LIN_W-1:0] green_linear;
      logic signed [LIN_W-1:0] blue_linear;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] red_byte;
      logic [7:0] green_byte;
      logic [7:0] blue_byte;
   } rsp_payload_type;

   // floor square root, used only for constants
   function automatic logic [63:0] gam_isqrt64(input logic [63:0] n);
      logic [63:0] rem;
      logic [63:0] res;
      logic [63:0] bit_v;
      rem   = n;
      res   = '0;
      bit_v = 64'd1 << 62;
      for (int k = 0; k < 32; k++) begin
         if (rem >= res + bit_v) begin
            rem = rem - (res + bit_v);
            res = (res >> 1) + bit_v;
         end else begin
            res = res >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return res;
   endfunction

   // 2^(-2^-i) in q32
   function automatic logic [31:0] gam_exp_root(input int i);
      logic [63:0] r;
      r = 64'd1 << 31;
      for (int k = 1; k <= i; k++) begin
         r = gam_isqrt64(r << 32);
      end
      return r[31:0];
   endfunction

endpackage

// ===== design/gamma_enc_channel.sv =====
// ----------------------------------------------------------------------------
// gamma encoder channel
// one color channel: clamp, log2, divide by gamma, exp2 (a square root in legacy mode), scale to a byte
// ----------------------------------------------------------------------------
module gamma_enc_channel #(
   parameter int FRAC_BITS = gamma_enc_pkg::FRAC_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   advance,
   input  logic                                   legacy_mode,
   input  logic [15:0]                            gamma_q12,
   input  logic signed [gamma_enc_pkg::LIN_W-1:0] lin,
   output logic [7:0]                             byte_out
);
   import gamma_enc_pkg::*;

   localparam int XW = FRAC_BITS + 1;
   localparam logic [LIN_W:0]  ONE_W  = (LIN_W + 1)'(1) << FRAC_BITS;
   localparam logic [XW-1:0]   ONE_X  = XW'(1) << FRAC_BITS;
   localparam logic [32:0]     A_FULL = 33'(FRAC_BITS) << LOG_FRAC;
   localparam logic [31:0]     R_FIRST = gam_exp_root(1);

   // clamp stage
   logic [XW-1:0] x_in, x_ff;

   always_comb begin
      if (lin[LIN_W-1]) begin
         x_in = '0;
      end else if ({1'b0, lin} > ONE_W) begin
         x_in = ONE_X;
      end else begin
         x_in = XW'(lin);
      end
   end

   // log section, index 0 is the normalize stage
   logic [31:0] lz_in   [0:LOG_N], lz_ff   [0:LOG_N];
   logic [27:0] lf_in   [0:LOG_N], lf_ff   [0:LOG_N];
   logic [4:0]  lp_in   [0:LOG_N], lp_ff   [0:LOG_N];
   logic        frc_in  [0:LOG_N], frc_ff  [0:LOG_N];
   logic [7:0]  fby_in  [0:LOG_N], fby_ff  [0:LOG_N];
   logic [17:0] srad_in [0:LOG_N], srad_ff [0:LOG_N];
   logic [11:0] srem_in [0:LOG_N], srem_ff [0:LOG_N];
   logic [9:0]  sroot_in[0:LOG_N], sroot_ff[0:LOG_N];

   logic [4:0]     norm_p;
   logic [XW+17:0] leg_prod;

   always_comb begin
      norm_p = '0;
      for (int k = 0; k < XW - 1; k++) begin
         if (x_ff[k]) begin
            norm_p = 5'(k);
         end
      end
      leg_prod    = (XW + 18)'(x_ff) * (XW + 18)'(LEG_SCALE);
      lz_in[0]    = 32'(x_ff[XW-2:0]) << (5'd31 - norm_p);
      lf_in[0]    = '0;
      lp_in[0]    = norm_p;
      frc_in[0]   = (x_ff == '0) || (x_ff == ONE_X);
      fby_in[0]   = (x_ff == ONE_X) ? 8'hFF : 8'h00;
      srad_in[0]  = 18'(leg_prod >> FRAC_BITS);
      srem_in[0]  = '0;
      sroot_in[0] = '0;
   end

   for (genvar i = 0; i < LOG_N; i++) begin : g_log
      localparam logic [27:0] BIT_M = 28'd1 << (LOG_FRAC - 1 - i);
      logic [63:0] sq;
      logic [32:0] zz;
      logic [7:0]  leg_byte;

      // repeated squaring yields one fraction bit of log2
      always_comb begin
         sq = lz_ff[i] * lz_ff[i];
         zz = sq[63:31];
         if (zz[32]) begin
            lz_in[i+1] = zz[32:1];
            lf_in[i+1] = lf_ff[i] | BIT_M;
         end else begin
            lz_in[i+1] = zz[31:0];
            lf_in[i+1] = lf_ff[i];
         end
         lp_in[i+1]   = lp_ff[i];
         srad_in[i+1] = srad_ff[i];
      end

      // legacy square root, one result bit per stage
      if (i < ROOT_N) begin : g_root
         logic [11:0] sh;
         logic [11:0] tr;
         always_comb begin
            sh = {srem_ff[i][9:0], srad_ff[i][17-2*i -: 2]};
            tr = {sroot_ff[i], 2'b01};
            if (sh >= tr) begin
               srem_in[i+1]  = sh - tr;
               sroot_in[i+1] = {sroot_ff[i][8:0], 1'b1};
            end else begin
               srem_in[i+1]  = sh;
               sroot_in[i+1] = {sroot_ff[i][8:0], 1'b0};
            end
         end
      end else begin : g_pass
         assign srem_in[i+1]  = srem_ff[i];
         assign sroot_in[i+1] = sroot_ff[i];
      end

      // legacy result takes over at the end of the section
      always_comb begin
         leg_byte = 8'((11'(sroot_ff[i]) + 11'd1) >> 1);
         if ((i == LOG_N - 1) && legacy_mode) begin
            frc_in[i+1] = 1'b1;
            fby_in[i+1] = leg_byte;
         end else begin
            frc_in[i+1] = frc_ff[i];
            fby_in[i+1] = fby_ff[i];
         end
      end
   end

   // divide section, index 0 forms the negative log
   logic [15:0] dr_in  [0:DIV_N], dr_ff  [0:DIV_N];
   logic [33:0] dlo_in [0:DIV_N], dlo_ff [0:DIV_N];
   logic [33:0] dq_in  [0:DIV_N], dq_ff  [0:DIV_N];
   logic        dsat_in[0:DIV_N], dsat_ff[0:DIV_N];
   logic        dfrc_in[0:DIV_N], dfrc_ff[0:DIV_N];
   logic [7:0]  dfby_in[0:DIV_N], dfby_ff[0:DIV_N];
   logic [32:0] neg_log;

   always_comb begin
      neg_log    = A_FULL - {lp_ff[LOG_N], lf_ff[LOG_N]};
      dr_in[0]   = 16'(neg_log[32:22]);
      dsat_in[0] = 16'(neg_log[32:22]) >= gamma_q12;
      dlo_in[0]  = {neg_log[21:0], 12'b0};
      dq_in[0]   = '0;
      dfrc_in[0] = frc_ff[LOG_N];
      dfby_in[0] = fby_ff[LOG_N];
   end

   for (genvar k = 0; k < DIV_N; k++) begin : g_div
      localparam logic [33:0] QBIT = 34'd1 << (DIV_N - 1 - k);
      logic [16:0] r2;
      always_comb begin
         r2 = {dr_ff[k], dlo_ff[k][DIV_N-1-k]};
         if (r2 >= {1'b0, gamma_q12}) begin
            dr_in[k+1] = 16'(r2 - {1'b0, gamma_q12});
            dq_in[k+1] = dq_ff[k] | QBIT;
         end else begin
            dr_in[k+1] = r2[15:0];
            dq_in[k+1] = dq_ff[k];
         end
         dlo_in[k+1]  = dlo_ff[k];
         dsat_in[k+1] = dsat_ff[k];
         dfrc_in[k+1] = dfrc_ff[k];
         dfby_in[k+1] = dfby_ff[k];
      end
   end

   // exp section, index 0 applies the first root without a multiply
   logic [32:0] ey_in  [0:EXP_N-1], ey_ff  [0:EXP_N-1];
   logic [27:0] ef_in  [0:EXP_N-1], ef_ff  [0:EXP_N-1];
   logic [5:0]  en_in  [0:EXP_N-1], en_ff  [0:EXP_N-1];
   logic        esat_in[0:EXP_N-1], esat_ff[0:EXP_N-1];
   logic        efrc_in[0:EXP_N-1], efrc_ff[0:EXP_N-1];
   logic [7:0]  efby_in[0:EXP_N-1], efby_ff[0:EXP_N-1];

   always_comb begin
      en_in[0]   = dq_ff[DIV_N][33:28];
      ef_in[0]   = dq_ff[DIV_N][27:0];
      esat_in[0] = dsat_ff[DIV_N] || (dq_ff[DIV_N][33:28] >= 6'd33);
      ey_in[0]   = dq_ff[DIV_N][27] ? {1'b0, R_FIRST} : 33'h1_0000_0000;
      efrc_in[0] = dfrc_ff[DIV_N];
      efby_in[0] = dfby_ff[DIV_N];
   end

   for (genvar j = 1; j < EXP_N; j++) begin : g_exp
      localparam logic [31:0] R_J = gam_exp_root(j + 1);
      logic [64:0] prod;
      always_comb begin
         prod = 65'(ey_ff[j-1]) * 65'(R_J);
         if (ef_ff[j-1][LOG_FRAC-1-j]) begin
            ey_in[j] = 33'(prod >> 32);
         end else begin
            ey_in[j] = ey_ff[j-1];
         end
         ef_in[j]   = ef_ff[j-1];
         en_in[j]   = en_ff[j-1];
         esat_in[j] = esat_ff[j-1];
         efrc_in[j] = efrc_ff[j-1];
         efby_in[j] = efby_ff[j-1];
      end
   end

   // integer part shift, then scale and round
   logic [32:0] ys_in, ys_ff;
   logic        ssat_ff, sfrc_ff;
   logic [7:0]  sfby_ff;
   logic [40:0] scaled;
   logic [7:0]  out_in, out_ff;

   assign ys_in = ey_ff[EXP_N-1] >> en_ff[EXP_N-1];

   always_comb begin
      scaled = 41'(ys_ff) * 41'(255) + (41'(1) << 31);
      if (sfrc_ff) begin
         out_in = sfby_ff;
      end else if (ssat_ff) begin
         out_in = 8'h00;
      end else if (scaled[40:32] > 9'd255) begin
         out_in = 8'hFF;
      end else begin
         out_in = scaled[39:32];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff <= x_in;
         for (int i = 0; i <= LOG_N; i++) begin
            lz_ff[i]    <= lz_in[i];
            lf_ff[i]    <= lf_in[i];
            lp_ff[i]    <= lp_in[i];
            frc_ff[i]   <= frc_in[i];
            fby_ff[i]   <= fby_in[i];
            srad_ff[i]  <= srad_in[i];
            srem_ff[i]  <= srem_in[i];
            sroot_ff[i] <= sroot_in[i];
         end
         for (int k = 0; k <= DIV_N; k++) begin
            dr_ff[k]   <= dr_in[k];
            dlo_ff[k]  <= dlo_in[k];
            dq_ff[k]   <= dq_in[k];
            dsat_ff[k] <= dsat_in[k];
            dfrc_ff[k] <= dfrc_in[k];
            dfby_ff[k] <= dfby_in[k];
         end
         for (int j = 0; j < EXP_N; j++) begin
            ey_ff[j]   <= ey_in[j];
            ef_ff[j]   <= ef_in[j];
            en_ff[j]   <= en_in[j];
            esat_ff[j] <= esat_in[j];
            efrc_ff[j] <= efrc_in[j];
            efby_ff[j] <= efby_in[j];
         end
         ys_ff   <= ys_in;
         ssat_ff <= esat_ff[EXP_N-1];
         sfrc_ff <= efrc_ff[EXP_N-1];
         sfby_ff <= efby_ff[EXP_N-1];
         out_ff  <= out_in;
      end
   end

   assign byte_out = out_ff;

endmodule

// ===== design/gamma_encode_rgb_to_byte.sv =====
// ----------------------------------------------------------------------------
// gamma encode rgb to byte
// one pixel per cycle while no result is held at the output; the pipeline is built
// from 28 log squarings, a 34-step divider and 28 exp stages
// a stalled result freezes the whole pipeline; synchronous reset clears valids
// and loads legacy square-root mode with gamma 2.2
// ----------------------------------------------------------------------------
`include "gamma_encode_rgb_to_byte_macros.svh"

module gamma_encode_rgb_to_byte #(
   parameter int FRAC_BITS = gamma_enc_pkg::FRAC_BITS_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   // pixel input transaction
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  gamma_enc_pkg::req_payload_type           req_data,
   // encoded byte transaction
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output gamma_enc_pkg::rsp_payload_type           rsp_data,
   // register writes
   input  logic                                     csr_we,
   input  logic [gamma_enc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [gamma_enc_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import gamma_enc_pkg::*;

   // configuration registers
   logic        legacy_ff;
   logic [15:0] gamma_ff;
   logic [15:0] gamma_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         legacy_ff <= 1'b1;
         gamma_ff  <= GAMMA_DEFAULT;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LEGACY_MODE: begin
               legacy_ff <= csr_wdata[0];
            end
            CSR_GAMMA_VALUE: begin
               gamma_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // zero in the gamma register falls back to 2.2
   assign gamma_eff = (gamma_ff == '0) ? GAMMA_DEFAULT : gamma_ff;

   // the whole pipeline moves unless a finished transaction is held at the output
   logic                advance;
   logic [PIPE_LAT-1:0] vld_ff;

   assign advance   = !(vld_ff[PIPE_LAT-1] && rsp_stall);
   assign req_stall = !advance;
   assign rsp_valid = vld_ff[PIPE_LAT-1];

   // valid bits ride alongside the channel data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[PIPE_LAT-2:0], req_valid};
      end
   end

   // three identical channel pipelines
   gamma_enc_channel #(.FRAC_BITS(FRAC_BITS)) u_red (
      .clock       (clock),
      .advance     (advance),
      .legacy_mode (legacy_ff),
      .gamma_q12   (gamma_eff),
      .lin         (req_data.red_linear),
      .byte_out    (rsp_data.red_byte)
   );

   gamma_enc_channel #(.FRAC_BITS(FRAC_BITS)) u_green (
      .clock       (clock),
      .advance     (advance),
      .legacy_mode (legacy_ff),
      .gamma_q12   (gamma_eff),
      .lin         (req_data.green_linear),
      .byte_out    (rsp_data.green_byte)
   );

   gamma_enc_channel #(.FRAC_BITS(FRAC_BITS)) u_blue (
      .clock       (clock),
      .advance     (advance),
      .legacy_mode (legacy_ff),
      .gamma_q12   (gamma_eff),
      .lin         (req_data.blue_linear),
      .byte_out    (rsp_data.blue_byte)
   );

   // accepted transaction enters the first valid stage
   `GAM_ASSERT_NEXT(a_accept_enters, clock, reset, req_valid && !req_stall, vld_ff[0])
   // a held result pushes back on the input
   `GAM_ASSERT_NOW(a_backpressure, clock, reset, rsp_valid && rsp_stall, req_stall)
   // last-but-one stage reaches the output when moving
   `GAM_ASSERT_NEXT(a_drain, clock, reset, !req_stall && vld_ff[PIPE_LAT-2], rsp_valid)
   // a frozen pipeline keeps its valid pattern
   `GAM_ASSERT_NEXT(a_freeze, clock, reset, req_stall, $stable(vld_ff))

endmodule
